// File: rtl/ccss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccss_pkg
// Types, codes and helpers shared by the clamped cubic spline solver core.
// ----------------------------------------------------------------------------
package ccss_pkg;

    localparam int RATIO_BITS  = 30;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 232;
    localparam int OUT_TUSER_W = 2;
    localparam int SEG_W       = 6;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_FEW      = 2'd1;
    localparam logic [1:0] ERR_MANY     = 2'd2;
    localparam logic [1:0] ERR_ZERO_SPAN = 2'd3;

    localparam logic CFG_START_SLOPE = 1'b0;
    localparam logic CFG_END_SLOPE   = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CHECK,
        ST_S_RD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_E_RD,
        ST_E_V,
        ST_E_MUL,
        ST_E_ACC,
        ST_B_RD,
        ST_B_MUL,
        ST_B_ACC,
        ST_O_RD,
        ST_O_MUL,
        ST_O_ACC,
        ST_O_WAIT
    } t_state;

    typedef enum logic [1:0] {
        DK_SEC,
        DK_W,
        DK_F,
        DK_R
    } t_div_kind;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] res;
        if (v > 72'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -72'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/clamped_cubic_spline_solver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamped_cubic_spline_solver_core
// Loads Q16.16 knots until the last one, solves the clamped cubic spline and
// streams out one coefficient set per segment.
// ----------------------------------------------------------------------------
// Knots are taken one per cycle. The item with tlast set starts the solve and
// the input stays not ready until the last segment item has been taken. The
// solve uses one divider and one multiplier under a sequencer: secants per
// segment, elimination per inner knot, back substitution, and output per
// segment, which waits on the receiver. An error run goes through the check
// state and offers its single item after the last knot is taken.
module clamped_cubic_spline_solver_core #(
    parameter int MAX_KNOTS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // knot_x [31:0], knot_y [63:32]
    input  logic [ccss_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tlast,
    output logic                              s_axis_tready,
    // segment_index [5:0], coef_a [37:6], coef_b [69:38], coef_c [101:70],
    // coef_d [133:102], param_offset [165:134], output_offset [197:166],
    // param_span [229:198], zero fill [231:230]
    output logic [ccss_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // error_code [1:0]
    output logic [ccss_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
    output logic                              m_axis_tvalid,
    output logic                              m_axis_tlast,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    output logic                              o_cfg_ready
);

    localparam int IW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
    localparam int CW = $clog2(MAX_KNOTS + 1);
    localparam logic signed [35:0] RATIO_ONE = 36'sd1 <<< ccss_pkg::RATIO_BITS;
    localparam int SEG_W_L = ccss_pkg::SEG_W;

    // Knot stores and solver stores.
    logic signed [31:0] r_mem_x [MAX_KNOTS];
    logic signed [31:0] r_mem_y [MAX_KNOTS];
    logic signed [32:0] r_mem_h [MAX_KNOTS];
    logic signed [32:0] r_mem_d [MAX_KNOTS];
    logic signed [31:0] r_mem_s [MAX_KNOTS];
    logic signed [31:0] r_mem_f [MAX_KNOTS];
    logic signed [31:0] r_mem_r [MAX_KNOTS];

    logic signed [31:0] r_xrd, r_yrd, r_srd, r_frd, r_rrd;
    logic signed [32:0] r_hrd, r_drd;

    ccss_pkg::t_state    r_state, n_state;
    ccss_pkg::t_div_kind r_dk, n_dk;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic          r_zero, n_zero;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_n, n_n;
    logic [2:0]    r_ms, n_ms;
    logic          r_ovalid, n_ovalid;
    logic signed [31:0] r_start_slope, r_end_slope;

    logic signed [31:0] r_xprev, n_xprev, r_yprev, n_yprev;
    logic signed [32:0] r_hp, n_hp;
    logic signed [31:0] r_sp, n_sp, r_w, n_w, r_v, n_v, r_f, n_f;
    logic signed [31:0] r_cprev, n_cprev, r_dprev, n_dprev, r_kl, n_kl;
    logic signed [31:0] r_b, n_b, r_e, n_e, r_num, n_num;
    logic signed [39:0] r_acc, n_acc;
    logic signed [35:0] r_piv, n_piv;
    logic signed [67:0] r_prod;

    logic [SEG_W_L-1:0] r_o_seg, n_o_seg;
    logic signed [31:0] r_o_a, n_o_a, r_o_b, n_o_b, r_o_c, n_o_c, r_o_d, n_o_d;
    logic signed [31:0] r_o_px, n_o_px, r_o_py, n_o_py, r_o_span, n_o_span;
    logic [1:0]         r_o_err, n_o_err;
    logic               r_o_last, n_o_last;

    logic [IW-1:0] addr_a, addr_r;
    logic          we_x, we_h, we_s, we_f, we_r;
    logic [IW-1:0] wa_x, wa_h;
    logic signed [31:0] wd_s, wd_f, wd_r;
    logic signed [32:0] wd_h, wd_d;

    logic signed [33:0] mul_a, mul_b;
    logic signed [37:0] p30;
    logic signed [71:0] pf;
    logic signed [31:0] kr;
    logic signed [31:0] in_x, in_y;
    logic               s_accept;

    logic               div_start, div_done;
    logic signed [63:0] div_num;
    logic signed [35:0] div_den;
    logic signed [31:0] div_q;

    logic signed [39:0] tmp_acc;
    logic signed [39:0] dy40;

    assign in_x     = s_axis_tdata[31:0];
    assign in_y     = s_axis_tdata[63:32];
    assign s_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == ccss_pkg::ST_LOAD);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = r_o_err;
    assign m_axis_tdata  = {2'b00, r_o_span, r_o_py, r_o_px, r_o_d, r_o_c, r_o_b,
                            r_o_a, r_o_seg};

    assign p30 = 38'(r_prod >>> ccss_pkg::RATIO_BITS);
    assign pf  = 72'(r_prod >>> FRAC_BITS);
    assign kr  = (r_idx == r_n - IW'(1)) ? r_end_slope : r_rrd;

    assign addr_a = r_idx;
    assign addr_r = (r_state == ccss_pkg::ST_O_RD || r_state == ccss_pkg::ST_O_MUL ||
                     r_state == ccss_pkg::ST_O_ACC) ? IW'(r_idx + IW'(1)) : r_idx;

    ccss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Divider operands follow the kind of quotient being formed.
    always_comb begin
        div_start = (r_state == ccss_pkg::ST_DIV_GO);
        unique case (r_dk)
            ccss_pkg::DK_SEC: begin
                div_num = 64'(r_drd) <<< FRAC_BITS;
                div_den = 36'(r_hrd);
            end
            ccss_pkg::DK_W: begin
                div_num = 64'(r_hrd) <<< ccss_pkg::RATIO_BITS;
                div_den = 36'(r_hp) + 36'(r_hrd);
            end
            ccss_pkg::DK_F: begin
                div_num = 64'(r_v) <<< ccss_pkg::RATIO_BITS;
                div_den = r_piv;
            end
            default: begin
                div_num = 64'(r_num) <<< ccss_pkg::RATIO_BITS;
                div_den = r_piv;
            end
        endcase
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ccss_pkg::ST_E_MUL: begin
                unique case (r_ms)
                    3'd0: begin mul_a = 34'(r_w); mul_b = 34'(r_sp); end
                    3'd1: begin mul_a = 34'(r_v); mul_b = 34'(r_srd); end
                    3'd2: begin mul_a = 34'(r_w); mul_b = 34'(r_start_slope); end
                    3'd3: begin mul_a = 34'(r_v); mul_b = 34'(r_end_slope); end
                    3'd4: begin mul_a = 34'(r_w); mul_b = 34'(r_cprev); end
                    default: begin mul_a = 34'(r_w); mul_b = 34'(r_dprev); end
                endcase
            end
            ccss_pkg::ST_B_MUL: begin
                mul_a = 34'(r_frd);
                mul_b = 34'(r_dprev);
            end
            ccss_pkg::ST_O_MUL: begin
                mul_a = 34'(r_hrd);
                if (r_ms == 3'd0) begin
                    mul_b = (r_idx == '0) ? 34'(r_start_slope) : 34'(r_kl);
                end else begin
                    mul_b = 34'(kr);
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_dk     = r_dk;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_zero   = r_zero;
        n_idx    = r_idx;
        n_n      = r_n;
        n_ms     = r_ms;
        n_ovalid = r_ovalid;
        n_xprev  = r_xprev;
        n_yprev  = r_yprev;
        n_hp     = r_hp;
        n_sp     = r_sp;
        n_w      = r_w;
        n_v      = r_v;
        n_f      = r_f;
        n_cprev  = r_cprev;
        n_dprev  = r_dprev;
        n_kl     = r_kl;
        n_b      = r_b;
        n_e      = r_e;
        n_num    = r_num;
        n_acc    = r_acc;
        n_piv    = r_piv;
        n_o_seg  = r_o_seg;
        n_o_a    = r_o_a;
        n_o_b    = r_o_b;
        n_o_c    = r_o_c;
        n_o_d    = r_o_d;
        n_o_px   = r_o_px;
        n_o_py   = r_o_py;
        n_o_span = r_o_span;
        n_o_err  = r_o_err;
        n_o_last = r_o_last;
        we_x     = 1'b0;
        we_h     = 1'b0;
        we_s     = 1'b0;
        we_f     = 1'b0;
        we_r     = 1'b0;
        wa_x     = r_cnt[IW-1:0];
        wa_h     = IW'(r_cnt - CW'(1));
        wd_h     = 33'(in_x) - 33'(r_xprev);
        wd_d     = 33'(in_y) - 33'(r_yprev);
        wd_s     = div_q;
        wd_f     = div_q;
        wd_r     = div_q;
        tmp_acc  = '0;
        dy40     = 40'(r_drd);

        unique case (r_state)
            ccss_pkg::ST_LOAD: begin
                if (s_accept) begin
                    if (r_cnt < CW'(MAX_KNOTS)) begin
                        we_x    = 1'b1;
                        n_cnt   = r_cnt + CW'(1);
                        n_xprev = in_x;
                        n_yprev = in_y;
                        if (r_cnt != '0) begin
                            we_h = 1'b1;
                            if (in_x == r_xprev) begin
                                n_zero = 1'b1;
                            end
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_state = ccss_pkg::ST_CHECK;
                    end
                end
            end

            ccss_pkg::ST_CHECK: begin
                n_cnt  = '0;
                n_ovf  = 1'b0;
                n_zero = 1'b0;
                n_n    = IW'(r_cnt - CW'(1));
                n_idx  = '0;
                if (r_ovf || r_cnt < CW'(2) || r_zero) begin
                    // A failed run gives a single item with all payload cleared.
                    priority if (r_ovf) begin
                        n_o_err = ccss_pkg::ERR_MANY;
                    end else if (r_cnt < CW'(2)) begin
                        n_o_err = ccss_pkg::ERR_FEW;
                    end else begin
                        n_o_err = ccss_pkg::ERR_ZERO_SPAN;
                    end
                    n_o_seg  = '0;
                    n_o_a    = '0;
                    n_o_b    = '0;
                    n_o_c    = '0;
                    n_o_d    = '0;
                    n_o_px   = '0;
                    n_o_py   = '0;
                    n_o_span = '0;
                    n_o_last = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = ccss_pkg::ST_O_WAIT;
                end else begin
                    n_state = ccss_pkg::ST_S_RD;
                end
            end

            ccss_pkg::ST_S_RD: begin
                n_dk    = ccss_pkg::DK_SEC;
                n_state = ccss_pkg::ST_DIV_GO;
            end

            ccss_pkg::ST_DIV_GO: begin
                n_state = ccss_pkg::ST_DIV_WAIT;
            end

            ccss_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    unique case (r_dk)
                        ccss_pkg::DK_SEC: begin
                            we_s = 1'b1;
                            if (r_idx == '0) begin
                                n_hp = r_hrd;
                                n_sp = div_q;
                            end
                            if (r_idx == r_n - IW'(1)) begin
                                if (r_n == IW'(1)) begin
                                    n_idx   = '0;
                                    n_ms    = 3'd0;
                                    n_state = ccss_pkg::ST_O_RD;
                                end else begin
                                    n_idx   = IW'(1);
                                    n_cprev = '0;
                                    n_dprev = '0;
                                    n_state = ccss_pkg::ST_E_RD;
                                end
                            end else begin
                                n_idx   = r_idx + IW'(1);
                                n_state = ccss_pkg::ST_S_RD;
                            end
                        end
                        ccss_pkg::DK_W: begin
                            n_w     = div_q;
                            n_state = ccss_pkg::ST_E_V;
                        end
                        ccss_pkg::DK_F: begin
                            we_f    = 1'b1;
                            n_f     = div_q;
                            n_dk    = ccss_pkg::DK_R;
                            n_state = ccss_pkg::ST_DIV_GO;
                        end
                        default: begin
                            we_r    = 1'b1;
                            n_dprev = div_q;
                            n_cprev = r_f;
                            n_hp    = r_hrd;
                            n_sp    = r_srd;
                            if (r_idx == r_n - IW'(1)) begin
                                if (int'(r_n) >= 3) begin
                                    n_idx   = r_n - IW'(2);
                                    n_state = ccss_pkg::ST_B_RD;
                                end else begin
                                    n_idx   = '0;
                                    n_ms    = 3'd0;
                                    n_state = ccss_pkg::ST_O_RD;
                                end
                            end else begin
                                n_idx   = r_idx + IW'(1);
                                n_state = ccss_pkg::ST_E_RD;
                            end
                        end
                    endcase
                end
            end

            ccss_pkg::ST_E_RD: begin
                n_dk    = ccss_pkg::DK_W;
                n_state = ccss_pkg::ST_DIV_GO;
            end

            ccss_pkg::ST_E_V: begin
                n_v     = ccss_pkg::sat32(72'(RATIO_ONE - 36'(r_w)));
                n_ms    = 3'd0;
                n_state = ccss_pkg::ST_E_MUL;
            end

            ccss_pkg::ST_E_MUL: begin
                n_state = ccss_pkg::ST_E_ACC;
            end

            ccss_pkg::ST_E_ACC: begin
                n_ms    = r_ms + 3'd1;
                n_state = ccss_pkg::ST_E_MUL;
                unique case (r_ms)
                    3'd0: n_acc = 40'(p30);
                    3'd1: begin
                        tmp_acc = r_acc + 40'(p30);
                        n_acc   = 40'(tmp_acc * 40'sd3);
                    end
                    3'd2: begin
                        if (int'(r_idx) == 1) begin
                            n_acc = r_acc - 40'(p30);
                        end
                    end
                    3'd3: begin
                        tmp_acc = (r_idx == r_n - IW'(1)) ? (r_acc - 40'(p30)) : r_acc;
                        n_acc   = 40'(ccss_pkg::sat32(72'(tmp_acc)));
                    end
                    3'd4: n_piv = (RATIO_ONE <<< 1) - 36'(p30);
                    default: begin
                        n_num   = ccss_pkg::sat32(72'(r_acc - 40'(p30)));
                        n_dk    = ccss_pkg::DK_F;
                        n_state = ccss_pkg::ST_DIV_GO;
                    end
                endcase
            end

            ccss_pkg::ST_B_RD: begin
                n_state = ccss_pkg::ST_B_MUL;
            end

            ccss_pkg::ST_B_MUL: begin
                n_state = ccss_pkg::ST_B_ACC;
            end

            ccss_pkg::ST_B_ACC: begin
                // The slope of the next knot up is carried in r_dprev.
                wd_r    = ccss_pkg::sat32(72'(40'(r_rrd) - 40'(p30)));
                we_r    = 1'b1;
                n_dprev = wd_r;
                if (int'(r_idx) == 1) begin
                    n_idx   = '0;
                    n_ms    = 3'd0;
                    n_state = ccss_pkg::ST_O_RD;
                end else begin
                    n_idx   = r_idx - IW'(1);
                    n_state = ccss_pkg::ST_B_RD;
                end
            end

            ccss_pkg::ST_O_RD: begin
                n_ms    = 3'd0;
                n_state = ccss_pkg::ST_O_MUL;
            end

            ccss_pkg::ST_O_MUL: begin
                n_state = ccss_pkg::ST_O_ACC;
            end

            ccss_pkg::ST_O_ACC: begin
                if (r_ms == 3'd0) begin
                    n_b     = ccss_pkg::sat32(pf);
                    n_ms    = 3'd1;
                    n_state = ccss_pkg::ST_O_MUL;
                end else begin
                    n_e      = ccss_pkg::sat32(pf);
                    n_kl     = kr;
                    tmp_acc  = 40'(n_e);
                    n_o_c    = ccss_pkg::sat32(72'(dy40 * 40'sd3 - (40'(r_b) <<< 1) - tmp_acc));
                    n_o_d    = ccss_pkg::sat32(72'(40'(r_b) + tmp_acc - (dy40 <<< 1)));
                    n_o_seg  = SEG_W_L'(r_idx);
                    n_o_a    = r_yrd;
                    n_o_b    = r_b;
                    n_o_px   = r_xrd;
                    n_o_py   = r_yrd;
                    n_o_span = ccss_pkg::sat32(72'(r_hrd));
                    n_o_err  = ccss_pkg::ERR_NONE;
                    n_o_last = (r_idx == r_n - IW'(1));
                    n_ovalid = 1'b1;
                    n_state  = ccss_pkg::ST_O_WAIT;
                end
            end

            ccss_pkg::ST_O_WAIT: begin
                if (m_axis_tready) begin
                    n_ovalid = 1'b0;
                    if (r_o_last) begin
                        n_state = ccss_pkg::ST_LOAD;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = ccss_pkg::ST_O_RD;
                    end
                end
            end

            default: n_state = ccss_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ccss_pkg::ST_LOAD;
            r_cnt         <= '0;
            r_ovf         <= 1'b0;
            r_zero        <= 1'b0;
            r_ovalid      <= 1'b0;
            r_start_slope <= 32'sd65536;
            r_end_slope   <= 32'sd65536;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_zero   <= n_zero;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    ccss_pkg::CFG_START_SLOPE: r_start_slope <= i_cfg_data;
                    ccss_pkg::CFG_END_SLOPE:   r_end_slope   <= i_cfg_data;
                    default:                   r_end_slope   <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dk     <= n_dk;
        r_idx    <= n_idx;
        r_n      <= n_n;
        r_ms     <= n_ms;
        r_xprev  <= n_xprev;
        r_yprev  <= n_yprev;
        r_hp     <= n_hp;
        r_sp     <= n_sp;
        r_w      <= n_w;
        r_v      <= n_v;
        r_f      <= n_f;
        r_cprev  <= n_cprev;
        r_dprev  <= n_dprev;
        r_kl     <= n_kl;
        r_b      <= n_b;
        r_e      <= n_e;
        r_num    <= n_num;
        r_acc    <= n_acc;
        r_piv    <= n_piv;
        r_prod   <= 68'(mul_a) * 68'(mul_b);
        r_o_seg  <= n_o_seg;
        r_o_a    <= n_o_a;
        r_o_b    <= n_o_b;
        r_o_c    <= n_o_c;
        r_o_d    <= n_o_d;
        r_o_px   <= n_o_px;
        r_o_py   <= n_o_py;
        r_o_span <= n_o_span;
        r_o_err  <= n_o_err;
        r_o_last <= n_o_last;
    end

    always_ff @(posedge i_clk) begin
        if (we_x) begin
            r_mem_x[wa_x] <= in_x;
            r_mem_y[wa_x] <= in_y;
        end
        if (we_h) begin
            r_mem_h[wa_h] <= wd_h;
            r_mem_d[wa_h] <= wd_d;
        end
        if (we_s) begin
            r_mem_s[r_idx] <= wd_s;
        end
        if (we_f) begin
            r_mem_f[r_idx] <= wd_f;
        end
        if (we_r) begin
            r_mem_r[r_idx] <= wd_r;
        end
        r_xrd <= r_mem_x[addr_a];
        r_yrd <= r_mem_y[addr_a];
        r_hrd <= r_mem_h[addr_a];
        r_drd <= r_mem_d[addr_a];
        r_srd <= r_mem_s[addr_a];
        r_frd <= r_mem_f[addr_a];
        r_rrd <= r_mem_r[addr_r];
    end

endmodule

// File: rtl/ccss_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccss_div
// Radix-2 restoring divider, one quotient bit per cycle. The quotient
// truncates toward zero, saturates to 32 bits, and is zero for a zero divisor.
// ----------------------------------------------------------------------------
module ccss_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [35:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [35:0] r_rem;
    logic [63:0] r_quo;
    logic [35:0] r_dmag;
    logic        r_neg;
    logic        r_dz;

    logic [36:0] rem_sh;
    logic        fits;

    assign rem_sh = {r_rem, r_quo[63]};
    assign fits   = rem_sh >= {1'b0, r_dmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd63);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_num[63] ? (~i_num + 64'd1) : i_num;
            r_dmag <= i_den[35] ? (~i_den + 36'd1) : i_den;
            r_neg  <= i_num[63] ^ i_den[35];
            r_dz   <= (i_den == '0);
        end else if (r_busy) begin
            r_rem <= fits ? 36'(rem_sh - {1'b0, r_dmag}) : rem_sh[35:0];
            r_quo <= {r_quo[62:0], fits};
        end
    end

    always_comb begin
        o_done = r_done;
        if (r_dz) begin
            o_quot = '0;
        end else if (r_neg) begin
            o_quot = (r_quo > 64'h80000000) ? 32'sh80000000 : 32'(~r_quo + 64'd1);
        end else begin
            o_quot = (r_quo > 64'h7fffffff) ? 32'sh7fffffff : r_quo[31:0];
        end
    end

endmodule

// File: dv/tb_clamped_cubic_spline_solver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clamped_cubic_spline_solver_core
// Self-checking bench for the spline solver core. Knot runs of random size
// and content are streamed in, each run is solved by a behavioral spline
// predictor, and every segment item from the core is checked against it.
// ----------------------------------------------------------------------------
module tb_clamped_cubic_spline_solver_core;

    localparam int MAXK = 64;
    localparam int FB = 16;
    localparam longint ONE_Q30 = 64'sd1 << ccss_pkg::RATIO_BITS;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        last;
    } t_knot;

    typedef struct packed {
        logic [5:0]  seg;
        logic [31:0] a, b, c, d, px, py, span;
        logic [1:0]  err;
        logic        last;
    } t_segment;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic [ccss_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tvalid = 1'b0, s_axis_tlast = 1'b0, s_axis_tready;
    logic [ccss_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [ccss_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
    logic m_axis_tvalid, m_axis_tlast;
    logic m_axis_tready = 1'b0;
    logic i_cfg_valid = 1'b0, i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic o_cfg_ready;

    clamped_cubic_spline_solver_core u_top (.*);

    t_knot    knot_queue[$];
    t_segment segment_queue[$];
    int       errors = 0;
    longint   cycle_count = 0;
    bit       hold_rx = 1'b0;
    bit       in_taken = 1'b0;
    int       gap_left = 0, burst_left = 0;

    // Predictor state.
    longint xs[MAXK], ys[MAXK], fac[MAXK], rhs[MAXK];
    int     knot_total = 0;
    bit     knot_overflow = 1'b0;
    longint slope_start = 65536, slope_end = 65536;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint div_trunc(longint n, longint dv);
        if (dv == 0) return 0;
        return n / dv;
    endfunction

    // Absorb one knot and queue the segment items a closing knot produces.
    task automatic predict_knot(t_knot k);
        longint h[MAXK], sec[MAXK];
        longint w, v, r, cp, dp, piv, num, kl, kr, dy, b, e;
        int n, err;
        t_segment s;
        err = ccss_pkg::ERR_NONE;
        if (knot_total < MAXK) begin
            xs[knot_total] = longint'(signed'(k.x));
            ys[knot_total] = longint'(signed'(k.y));
            knot_total++;
        end else begin
            knot_overflow = 1'b1;
        end
        if (!k.last) return;
        if (knot_overflow) err = ccss_pkg::ERR_MANY;
        else if (knot_total < 2) err = ccss_pkg::ERR_FEW;
        n = (knot_total >= 1) ? knot_total - 1 : 0;
        for (int i = 0; err == ccss_pkg::ERR_NONE && i < n; i++) begin
            h[i] = xs[i+1] - xs[i];
            if (h[i] == 0) err = ccss_pkg::ERR_ZERO_SPAN;
        end
        knot_total = 0;
        knot_overflow = 1'b0;
        if (err != ccss_pkg::ERR_NONE) begin
            s = '0;
            s.err = 2'(err);
            s.last = 1'b1;
            segment_queue.insert(segment_queue.size(), s);
            return;
        end
        for (int i = 0; i < n; i++)
            sec[i] = clamp32(div_trunc((ys[i+1] - ys[i]) * (64'sd1 << FB), h[i]));
        for (int j = 1; j < n; j++) begin
            w = clamp32(div_trunc(h[j] * ONE_Q30, h[j-1] + h[j]));
            v = clamp32(ONE_Q30 - w);
            r = 3 * (shr_floor(w * sec[j-1], ccss_pkg::RATIO_BITS) +
                     shr_floor(v * sec[j], ccss_pkg::RATIO_BITS));
            cp = (j == 1) ? 0 : fac[j-1];
            dp = (j == 1) ? 0 : rhs[j-1];
            if (j == 1) r -= shr_floor(w * slope_start, ccss_pkg::RATIO_BITS);
            if (j == n - 1) r -= shr_floor(v * slope_end, ccss_pkg::RATIO_BITS);
            r = clamp32(r);
            piv = 2 * ONE_Q30 - shr_floor(w * cp, ccss_pkg::RATIO_BITS);
            fac[j] = clamp32(div_trunc(v * ONE_Q30, piv));
            num = clamp32(r - shr_floor(w * dp, ccss_pkg::RATIO_BITS));
            rhs[j] = clamp32(div_trunc(num * ONE_Q30, piv));
        end
        for (int j = n - 2; j >= 1; j--)
            rhs[j] = clamp32(rhs[j] - shr_floor(fac[j] * rhs[j+1], ccss_pkg::RATIO_BITS));
        for (int i = 0; i < n; i++) begin
            kl = (i == 0) ? slope_start : rhs[i];
            kr = (i + 1 == n) ? slope_end : rhs[i+1];
            dy = ys[i+1] - ys[i];
            b = clamp32(shr_floor(h[i] * kl, FB));
            e = clamp32(shr_floor(h[i] * kr, FB));
            s.seg = i[5:0];
            s.a = ys[i][31:0];
            s.b = b[31:0];
            s.c = 32'(clamp32(3 * dy - 2 * b - e));
            s.d = 32'(clamp32(b + e - 2 * dy));
            s.px = xs[i][31:0];
            s.py = ys[i][31:0];
            s.span = 32'(clamp32(h[i]));
            s.err = ccss_pkg::ERR_NONE;
            s.last = (i + 1 == n);
            segment_queue.insert(segment_queue.size(), s);
        end
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 64'd12000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Input monitor: every accepted knot goes to the predictor.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            predict_knot({s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tlast});
    end

    // Knot driver: bursts of items with random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            if (gap_left > 0 || knot_queue.size() == 0) begin
                s_axis_tvalid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                t_knot k;
                k = knot_queue.pop_front();
                s_axis_tdata <= {k.y, k.x};
                s_axis_tlast <= k.last;
                s_axis_tvalid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Receiver: random stall pattern, plus an external hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_rx) m_axis_tready <= 1'b0;
        else m_axis_tready <= (cycle_count[9:7] == 3'd5) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    // Segment checker.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_segment got, want;
            got.seg  = m_axis_tdata[5:0];
            got.a    = m_axis_tdata[37:6];
            got.b    = m_axis_tdata[69:38];
            got.c    = m_axis_tdata[101:70];
            got.d    = m_axis_tdata[133:102];
            got.px   = m_axis_tdata[165:134];
            got.py   = m_axis_tdata[197:166];
            got.span = m_axis_tdata[229:198];
            got.err  = m_axis_tuser;
            got.last = m_axis_tlast;
            if (segment_queue.size() == 0) begin
                $error("unexpected segment item %h", got);
                errors++;
            end else begin
                want = segment_queue.pop_front();
                if (got.seg !== want.seg)
                    $error("segment_index exp %0d got %0d", want.seg, got.seg);
                if (got.a !== want.a) $error("coef_a exp %h got %h", want.a, got.a);
                if (got.b !== want.b) $error("coef_b exp %h got %h", want.b, got.b);
                if (got.c !== want.c) $error("coef_c exp %h got %h", want.c, got.c);
                if (got.d !== want.d) $error("coef_d exp %h got %h", want.d, got.d);
                if (got.px !== want.px)
                    $error("param_offset exp %h got %h", want.px, got.px);
                if (got.py !== want.py)
                    $error("output_offset exp %h got %h", want.py, got.py);
                if (got.span !== want.span)
                    $error("param_span exp %h got %h", want.span, got.span);
                if (got.err !== want.err)
                    $error("error_code exp %0d got %0d", want.err, got.err);
                if (got.last !== want.last)
                    $error("last_segment exp %0d got %0d", want.last, got.last);
                if (got !== want) errors++;
            end
        end
    end

    task automatic add_knot(logic [31:0] x, logic [31:0] y, logic last);
        t_knot k;
        k.x = x;
        k.y = y;
        k.last = last;
        knot_queue.insert(knot_queue.size(), k);
    endtask

    // A run of n knots with random steps and values.
    task automatic add_run(int n, int step_max, bit wild_y);
        logic [31:0] x, y;
        x = $urandom();
        x[31] = $urandom_range(0, 1) ? x[31] : 1'b1;
        for (int i = 0; i < n; i++) begin
            y = wild_y ? $urandom() : $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            add_knot(x, y, i == n - 1);
            x = x + $urandom_range(1, step_max);
        end
    endtask

    task automatic drain();
        wait (knot_queue.size() == 0 && !s_axis_tvalid);
        wait (segment_queue.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == ccss_pkg::CFG_START_SLOPE) slope_start = longint'(signed'(val));
        else slope_end = longint'(signed'(val));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int sent;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed runs at reset slopes.
        add_knot(32'h0, 32'h7fff_ffff, 1'b1);               // one knot only
        add_knot(32'h0001_0000, 32'h0, 1'b0);
        add_knot(32'h0001_0000, 32'h1, 1'b1);               // zero span
        add_knot(32'h8000_0000, 32'h8000_0000, 1'b0);
        add_knot(32'h7fff_ffff, 32'h7fff_ffff, 1'b1);       // widest span
        add_knot(32'h0, 32'h0, 1'b0);
        add_knot(32'h0001_0000, 32'h0002_0000, 1'b0);
        add_knot(32'h0003_0000, 32'hffff_0000, 1'b0);
        add_knot(32'h0003_0001, 32'h8000_0000, 1'b1);
        add_knot(32'h5, 32'h7fff_ffff, 1'b0);
        add_knot(32'h4, 32'h0, 1'b1);                       // unsorted pair
        for (int i = 0; i < 66; i++)                        // too many knots
            add_knot(i << 16, $urandom(), i == 65);
        drain();

        write_reg(ccss_pkg::CFG_START_SLOPE, 32'h8000_0000);
        write_reg(ccss_pkg::CFG_END_SLOPE, 32'h7fff_ffff);
        add_run(64, 32'h0002_0000, 1'b0);                   // the largest run
        add_run(3, 32'h7fff_0000, 1'b1);
        drain();

        // Hold the receiver while knots keep arriving.
        hold_rx = 1'b1;
        add_run(4, 32'h0001_0000, 1'b0);
        add_run(5, 32'h0001_0000, 1'b0);
        repeat (3000) @(posedge i_clk);
        hold_rx = 1'b0;
        drain();

        sent = 160;
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(ccss_pkg::CFG_START_SLOPE, (phase == 1) ? 32'h7fff_ffff : $urandom());
            write_reg(ccss_pkg::CFG_END_SLOPE, (phase == 2) ? 32'h8000_0000 :
                      $urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
            while (sent < 160 + (phase + 1) * 80) begin
                case ($urandom_range(0, 9))
                    0: begin
                        add_knot($urandom(), $urandom(), $urandom_range(0, 1));
                        sent++;
                    end
                    1: begin
                        add_run(2, 32'h0010_0000, 1'b1);
                        sent += 2;
                    end
                    default: begin
                        int n;
                        n = $urandom_range(2, 8);
                        add_run(n, ($urandom_range(0, 1) ? 32'h0004_0000 : 32'h7fff_ffff),
                                $urandom_range(0, 1));
                        sent += n;
                    end
                endcase
            end
            add_knot($urandom(), $urandom(), 1'b1);          // close any open run
            drain();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
